@@ rtl/sac_pkg.sv @@
// Package for the segmentation argmax colorizer: field widths, opcodes
// and the packed input and result word types. No dependencies.
`timescale 1ns / 1ps

package sac_pkg;

    localparam int SCORE_BITS      = 16;
    localparam int FRAC_BITS       = SCORE_BITS - 2;
    localparam int CLASS_W         = 4;
    localparam int COLOR_W         = 24;
    localparam int CHAN_W          = 8;
    localparam int MAX_CLASSES_DEF = 16;

    localparam logic OP_PAL_WR = 1'b0;
    localparam logic OP_SCORE  = 1'b1;

    typedef struct packed {
        logic                         opcode;
        logic [CLASS_W-1:0]           class_id;
        logic signed [SCORE_BITS-1:0] score;
        logic [COLOR_W-1:0]           color;
        logic                         last;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CLASS_W-1:0] winning_class;
    } t_out_word;

endpackage

@@ rtl/sac_scale.sv @@
// One color channel scaled by (score + 1.0) / 2.0, rounded half up and
// saturated to the channel range. Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_scale
    import sac_pkg::*;
(
    input  logic [CHAN_W-1:0]            i_chan,
    input  logic signed [SCORE_BITS-1:0] i_score,
    output logic [CHAN_W-1:0]            o_chan
);

    localparam logic signed [SCORE_BITS:0] ONE  = (SCORE_BITS+1)'(1) << FRAC_BITS;
    localparam logic [CHAN_W+SCORE_BITS:0] HALF = (CHAN_W+SCORE_BITS+1)'(1) << FRAC_BITS;

    logic signed [SCORE_BITS:0]   w_t;
    logic [CHAN_W+SCORE_BITS-1:0] w_prod;
    logic [CHAN_W+SCORE_BITS:0]   w_sum;
    logic [CHAN_W+1:0]            w_v;

    assign w_t    = $signed({i_score[SCORE_BITS-1], i_score}) + ONE;
    assign w_prod = {{SCORE_BITS{1'b0}}, i_chan} * {{CHAN_W{1'b0}}, w_t[SCORE_BITS-1:0]};
    assign w_sum  = {1'b0, w_prod} + HALF;
    assign w_v    = w_sum[CHAN_W+SCORE_BITS:FRAC_BITS+1];

    always_comb begin
        if (w_t[SCORE_BITS]) begin
            o_chan = '0;
        end else if (w_v[CHAN_W+1:CHAN_W] != 2'b00) begin
            o_chan = {CHAN_W{1'b1}};
        end else begin
            o_chan = w_v[CHAN_W-1:0];
        end
    end

endmodule

@@ rtl/segmentation_argmax_colorizer_top.sv @@
// A score word with last set goes from the input register to the result register.
// One word per cycle unless a held result stalls; one stage holds the running-max
// compare, the palette lookup and the channel scaling between the two registers.
// Reset (synchronous, active low) clears the handshake, the mode register and
// the pixel state; palette contents are not reset.
// Top level of the colorizer; depends on sac_pkg and sac_scale.
`timescale 1ns / 1ps

module segmentation_argmax_colorizer_top
    import sac_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [COLOR_W-1:0] r_palette [MAX_CLASSES];

    logic                         r_mode;
    t_in_word                     r_in;
    logic                         r_s1_vld;
    logic signed [SCORE_BITS-1:0] r_best_score;
    logic [CLASS_W-1:0]           r_best_class;
    logic                         r_have_best;
    t_out_word                    r_out;
    logic                         r_out_vld;

    logic                         n_s1_vld;
    logic signed [SCORE_BITS-1:0] n_best_score;
    logic [CLASS_W-1:0]           n_best_class;
    logic                         n_have_best;
    t_out_word                    n_out;

    logic               w_cls_ok;
    logic               w_take;
    logic               w_emit;
    logic               w_adv;
    logic               w_fire;
    logic               w_in_acc;
    logic [COLOR_W-1:0] w_col0;
    logic [COLOR_W-1:0] w_col_best;
    logic [CHAN_W-1:0]  w_sr;
    logic [CHAN_W-1:0]  w_sg;
    logic [CHAN_W-1:0]  w_sb;

    assign w_cls_ok = int'(r_in.class_id) < MAX_CLASSES;
    assign w_emit   = (r_in.opcode == OP_SCORE) && r_in.last;
    assign w_adv    = !w_emit || !r_out_vld || i_out_ready;
    assign w_fire   = r_s1_vld && w_adv;
    assign o_in_ready = !r_s1_vld || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_take = w_cls_ok && (!r_have_best || (r_in.score > r_best_score));

    always_comb begin
        n_best_score = r_best_score;
        n_best_class = r_best_class;
        n_have_best  = r_have_best;
        if (w_take) begin
            n_best_score = r_in.score;
            n_best_class = r_in.class_id;
            n_have_best  = 1'b1;
        end
    end

    assign w_col0     = r_palette[0];
    assign w_col_best = r_palette[IDX_W'(n_best_class)];

    sac_scale u_scale_r (
        .i_chan  (w_col0[3*CHAN_W-1:2*CHAN_W]),
        .i_score (r_in.score),
        .o_chan  (w_sr)
    );

    sac_scale u_scale_g (
        .i_chan  (w_col0[2*CHAN_W-1:CHAN_W]),
        .i_score (r_in.score),
        .o_chan  (w_sg)
    );

    sac_scale u_scale_b (
        .i_chan  (w_col0[CHAN_W-1:0]),
        .i_score (r_in.score),
        .o_chan  (w_sb)
    );

    always_comb begin
        if (r_mode) begin
            n_out.red           = w_sr;
            n_out.green         = w_sg;
            n_out.blue          = w_sb;
            n_out.winning_class = '0;
        end else begin
            n_out.red           = w_col_best[3*CHAN_W-1:2*CHAN_W];
            n_out.green         = w_col_best[2*CHAN_W-1:CHAN_W];
            n_out.blue          = w_col_best[CHAN_W-1:0];
            n_out.winning_class = n_best_class;
        end
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_in_acc) begin
            n_s1_vld = 1'b1;
        end else if (w_fire) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_best_score <= '0;
            r_best_class <= '0;
            r_have_best  <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_s1_vld <= n_s1_vld;
            if (w_fire && (r_in.opcode == OP_SCORE)) begin
                if (r_in.last) begin
                    r_best_score <= '0;
                    r_best_class <= '0;
                    r_have_best  <= 1'b0;
                end else if (!r_mode) begin
                    r_best_score <= n_best_score;
                    r_best_class <= n_best_class;
                    r_have_best  <= n_have_best;
                end
            end
            if (w_fire && w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_word;
        end
        if (w_fire && w_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (r_in.opcode == OP_PAL_WR) && w_cls_ok) begin
            r_palette[IDX_W'(r_in.class_id)] <= r_in.color;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule
